// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/fnsc_pkg.sv =====
// types, codes and tables of the floppy note stepper controller
package fnsc_pkg;

    localparam int NOTE_TABLE_DEPTH_DEF = 128;

    localparam logic [7:0] MAX_HEAD_RESET = 8'd158;
    localparam logic [6:0] MAX_NOTE_RESET = 7'd59;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_OFF  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        OP_CMD  = 2'd0,
        OP_TONE = 2'd1,
        OP_LED  = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic {
        CFG_MAX_HEAD = 1'b0,
        CFG_MAX_NOTE = 1'b1
    } t_cfg_addr;

    localparam logic [7:0] CMD_OFF       = 8'hFF;
    localparam logic [7:0] CMD_RUN       = 8'hFE;
    localparam logic [7:0] CMD_IDLE      = 8'hFD;
    localparam logic [7:0] CMD_TONE_STOP = 8'h80;

    // one result word, highest bits first
    typedef struct packed {
        logic [7:0] head_position;
        logic [1:0] run_mode;
        logic       blue_lit;
        logic       green_lit;
        logic       red_lit;
        logic       motor_on;
        logic       direction_down;
        logic       step_level;
    } t_result;

    // step period in tone ticks, by note number
    localparam logic [15:0] PERIOD_ROM [128] = '{
        16'd61156, 16'd57723, 16'd54483, 16'd51425, 16'd48539, 16'd45815, 16'd43243,
        16'd40816, 16'd38525, 16'd36363, 16'd34322, 16'd32396, 16'd30578, 16'd28861,
        16'd27241, 16'd25712, 16'd24269, 16'd22907, 16'd21621, 16'd20408, 16'd19262,
        16'd18181, 16'd17161, 16'd16198, 16'd15289, 16'd14430, 16'd13620, 16'd12856,
        16'd12134, 16'd11453, 16'd10810, 16'd10204, 16'd9631, 16'd9090, 16'd8580,
        16'd8099, 16'd7644, 16'd7215, 16'd6810, 16'd6428, 16'd6067, 16'd5726,
        16'd5405, 16'd5102, 16'd4815, 16'd4545, 16'd4290, 16'd4049, 16'd3822,
        16'd3607, 16'd3405, 16'd3214, 16'd3033, 16'd2863, 16'd2702, 16'd2551,
        16'd2407, 16'd2272, 16'd2145, 16'd2024, 16'd1911, 16'd1803, 16'd1702,
        16'd1607, 16'd1516, 16'd1431, 16'd1351, 16'd1275, 16'd1203, 16'd1136,
        16'd1072, 16'd1012, 16'd955, 16'd901, 16'd851, 16'd803, 16'd758,
        16'd715, 16'd675, 16'd637, 16'd601, 16'd568, 16'd536, 16'd506,
        16'd477, 16'd450, 16'd425, 16'd401, 16'd379, 16'd357, 16'd337,
        16'd318, 16'd300, 16'd284, 16'd268, 16'd253, 16'd238, 16'd225,
        16'd212, 16'd200, 16'd189, 16'd178, 16'd168, 16'd159, 16'd150,
        16'd142, 16'd134, 16'd126, 16'd119, 16'd112, 16'd106, 16'd100,
        16'd94, 16'd89, 16'd84, 16'd79, 16'd75, 16'd71, 16'd67,
        16'd63, 16'd59, 16'd56, 16'd53, 16'd50, 16'd47, 16'd44,
        16'd42, 16'd39
    };

    // rgb colour for a pitch class, red in the top byte
    function automatic logic [23:0] hue_of(input logic [3:0] pc);
        logic [23:0] rgb;
        unique case (pc)
            4'd0:    rgb = 24'hFF0000;
            4'd1:    rgb = 24'hFF2222;
            4'd2:    rgb = 24'hFFFF00;
            4'd3:    rgb = 24'hFF6600;
            4'd4:    rgb = 24'hFF00FF;
            4'd5:    rgb = 24'h0000FF;
            4'd6:    rgb = 24'h2222FF;
            4'd7:    rgb = 24'h00FFFF;
            4'd8:    rgb = 24'h33DDDD;
            4'd9:    rgb = 24'h00FF00;
            4'd10:   rgb = 24'h22FF22;
            4'd11:   rgb = 24'hFFFFFF;
            default: rgb = 24'h000000;
        endcase
        return rgb;
    endfunction

    // note mod 12: quotient by multiply with 43/512, exact below 128
    function automatic logic [3:0] pitch_class(input logic [6:0] note);
        logic [12:0] prod;
        logic [3:0]  q;
        logic [6:0]  q12;
        prod = 13'(note) * 13'd43;
        q    = prod[12:9];
        q12  = 7'({q, 3'b000}) + 7'({q, 2'b00});
        return 4'(note - q12);
    endfunction

endpackage

// ===== rtl/core/fnsc_out_buf.sv =====
// two-entry result buffer between the state update and the master stream
module fnsc_out_buf
    import fnsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_item,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_item
);

`include "assert_macros.svh"

    logic [1:0] r_count;
    logic [1:0] n_count;
    t_result    r_head;
    t_result    r_tail;
    logic       w_pop;

    assign w_pop   = (r_count != 2'd0) && i_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_space = (r_count != 2'd2);
    assign o_item  = r_head;

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_count == 2'd0 && i_push) || (r_count == 2'd1 && i_push && w_pop)) begin
            r_head <= i_item;
        end else if (r_count == 2'd2 && w_pop) begin
            r_head <= r_tail;
        end
        if (r_count == 2'd1 && i_push && !w_pop) begin
            r_tail <= i_item;
        end
    end

    `ASSERT_RST(a_count_range, i_clk, i_rst_n, r_count != 2'd3, "result buffer count out of range")
    `ASSERT_RST(a_no_push_full, i_clk, i_rst_n, !(i_push && r_count == 2'd2), "push into a full buffer")
    `ASSERT_RST(a_held_when_stalled, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_item)), "head word lost while stalled")

endmodule

// ===== rtl/core/floppy_note_stepper_controller.sv =====
// top level of the floppy note stepper controller
// Slave stream: one word per event. tuser is the kind (command byte, tone tick,
// LED tick, no-op), tdata the command byte, read only for command words.
// Master stream: one result word per accepted input word, the block's state
// after that event: step pin, direction, motor enable, the three LED levels of
// the PWM phase, mode and head position.
// Config channel: i_cfg_addr 0 writes the turn-around head position, 1 the
// highest note; always ready, write only while no word is in flight.
// Each result is registered in the result buffer as its input word is accepted.
// Throughput: one word per cycle while the result buffer has space; the
// whole state update is one pass of compares and increments from the state
// registers into a two-entry result buffer.
// Stall: while the master side stalls, the buffer absorbs up to two results;
// s_axis_tready drops only when both are held.
// Reset (synchronous, active low): mode idle, head 0 moving up, motor, tone and
// LEDs off, tone period of the last note-table entry, registers at defaults.
// Mode off ignores every word until the next reset.
module floppy_note_stepper_controller
    import fnsc_pkg::*;
#(
    parameter int NOTE_TABLE_DEPTH = NOTE_TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] command
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] step_level [1] direction_down [2] motor_on [3] red_lit [4] green_lit
    // [5] blue_lit [7:6] run_mode [15:8] head_position
    output logic [15:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_data
);

`include "assert_macros.svh"

    localparam logic [6:0] LAST_NOTE = 7'(NOTE_TABLE_DEPTH - 1);
    localparam logic [7:0] DEPTH_LIM = 8'(NOTE_TABLE_DEPTH - 1);

    logic        w_accept;
    logic        w_space;
    t_op         w_op;
    t_result     w_item;
    t_result     w_out_item;

    logic [7:0]  r_max_head;
    logic [6:0]  r_max_note;

    t_mode       r_mode,      n_mode;
    logic [7:0]  r_head,      n_head;
    logic        r_dir_down,  n_dir_down;
    logic        r_step,      n_step;
    logic        r_motor,     n_motor;
    logic        r_tone_en,   n_tone_en;
    logic        r_led_en,    n_led_en;
    logic [15:0] r_tone_cnt,  n_tone_cnt;
    logic [15:0] r_period,    n_period;
    logic [7:0]  r_phase,     n_phase;
    logic [7:0]  r_level [3];
    logic [7:0]  n_level [3];
    logic [2:0]  r_lit,       n_lit;

    logic [23:0] w_hue;
    logic        w_note_ok;
    logic        w_dir_tmp;

    assign w_op          = t_op'(s_axis_tuser);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = w_space;
    assign o_cfg_ready   = 1'b1;

    assign w_hue     = hue_of(pitch_class(s_axis_tdata[6:0]));
    assign w_note_ok = (s_axis_tdata <= {1'b0, r_max_note}) && (s_axis_tdata <= DEPTH_LIM);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_head <= MAX_HEAD_RESET;
            r_max_note <= MAX_NOTE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_addr'(i_cfg_addr))
                CFG_MAX_HEAD: r_max_head <= i_cfg_data;
                CFG_MAX_NOTE: r_max_note <= i_cfg_data[6:0];
            endcase
        end
    end

    // next state for one accepted word
    always_comb begin
        n_mode     = r_mode;
        n_head     = r_head;
        n_dir_down = r_dir_down;
        n_step     = r_step;
        n_motor    = r_motor;
        n_tone_en  = r_tone_en;
        n_led_en   = r_led_en;
        n_tone_cnt = r_tone_cnt;
        n_period   = r_period;
        n_phase    = r_phase;
        n_level    = r_level;
        n_lit      = r_lit;
        w_dir_tmp  = r_dir_down;
        if (w_accept && r_mode != MODE_OFF) begin
            unique case (w_op)
                OP_CMD: begin
                    priority if (s_axis_tdata == CMD_OFF) begin
                        n_mode = MODE_OFF;
                    end else if (s_axis_tdata == CMD_RUN) begin
                        n_led_en = 1'b1;
                        n_motor  = 1'b1;
                        n_mode   = MODE_RUN;
                    end else if (s_axis_tdata == CMD_IDLE) begin
                        n_mode    = MODE_IDLE;
                        n_level   = '{default: 8'h00};
                        n_tone_en = 1'b0;
                        n_led_en  = 1'b0;
                        n_lit     = 3'b000;
                        n_motor   = 1'b0;
                    end else if (r_mode == MODE_RUN && s_axis_tdata == CMD_TONE_STOP) begin
                        n_tone_en = 1'b0;
                        n_level   = '{default: 8'h00};
                    end else if (r_mode == MODE_RUN && w_note_ok) begin
                        n_period   = PERIOD_ROM[s_axis_tdata[6:0]];
                        n_tone_cnt = 16'd0;
                        n_tone_en  = 1'b1;
                        n_level[0] = w_hue[23:16];
                        n_level[1] = w_hue[15:8];
                        n_level[2] = w_hue[7:0];
                    end else begin
                        n_mode = r_mode;
                    end
                end
                OP_TONE: begin
                    if (r_tone_cnt != r_period) begin
                        n_tone_cnt = r_tone_cnt + 16'd1;
                    end else begin
                        n_tone_cnt = 16'd0;
                        if (r_tone_en) begin
                            // turn down at the top, back up at zero
                            if (r_head == r_max_head) begin
                                w_dir_tmp = 1'b1;
                            end
                            if (r_head == 8'd0) begin
                                w_dir_tmp = 1'b0;
                            end
                            n_dir_down = w_dir_tmp;
                            n_head     = w_dir_tmp ? r_head - 8'd1 : r_head + 8'd1;
                            n_step     = !r_step;
                        end
                    end
                end
                OP_LED: begin
                    if (r_led_en) begin
                        n_phase = r_phase + 8'd1;
                        for (int k = 0; k < 3; k++) begin
                            if (n_phase == 8'd0 && r_level[k] != 8'd0) begin
                                n_lit[k] = 1'b1;
                            end
                            if (n_phase == r_level[k]) begin
                                n_lit[k] = 1'b0;
                            end
                        end
                    end
                end
                OP_NOP: begin
                    n_mode = r_mode;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_head     <= 8'd0;
            r_dir_down <= 1'b0;
            r_step     <= 1'b0;
            r_motor    <= 1'b0;
            r_tone_en  <= 1'b0;
            r_led_en   <= 1'b0;
            r_tone_cnt <= 16'd0;
            r_period   <= PERIOD_ROM[LAST_NOTE];
            r_phase    <= 8'd0;
            r_level    <= '{default: 8'h00};
            r_lit      <= 3'b000;
        end else begin
            r_mode     <= n_mode;
            r_head     <= n_head;
            r_dir_down <= n_dir_down;
            r_step     <= n_step;
            r_motor    <= n_motor;
            r_tone_en  <= n_tone_en;
            r_led_en   <= n_led_en;
            r_tone_cnt <= n_tone_cnt;
            r_period   <= n_period;
            r_phase    <= n_phase;
            r_level    <= n_level;
            r_lit      <= n_lit;
        end
    end

    // result word shows the state after the event
    always_comb begin
        w_item.step_level     = n_step;
        w_item.direction_down = n_dir_down;
        w_item.motor_on       = n_motor;
        w_item.red_lit        = n_lit[0];
        w_item.green_lit      = n_lit[1];
        w_item.blue_lit       = n_lit[2];
        w_item.run_mode       = n_mode;
        w_item.head_position  = n_head;
    end

    fnsc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_item  (w_item),
        .o_space (w_space),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_item  (w_out_item)
    );

    assign m_axis_tdata = w_out_item;

    `ASSERT_RST(a_off_sticks, i_clk, i_rst_n, r_mode == MODE_OFF |=> r_mode == MODE_OFF, "left off mode without reset")
    `ASSERT_RST(a_count_le_period, i_clk, i_rst_n, r_tone_cnt <= r_period, "tone counter passed its period")
    `ASSERT_RST(a_step_on_tick, i_clk, i_rst_n, ($past(i_rst_n) && !$stable(r_step)) |-> $past(w_accept && w_op == OP_TONE && r_tone_en), "step pin moved without a tone tick")
    `ASSERT_RST(a_idle_dark, i_clk, i_rst_n, (r_mode == MODE_IDLE && !r_led_en) |-> (r_lit == 3'b000), "led lit with pwm stopped in idle")

endmodule
